### rtl/iol_pkg.sv
// Package for the indexed ordered list core: storage widths, request and
// status codes, the per-cell command and the control state type.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package iol_pkg;

    // Width of one stored value.
    localparam int DataW = 32;
    // Position and count width, wide enough for the largest supported store (4096).
    localparam int PosW = 13;
    // Default and upper bound of the store size.
    localparam int DefCapacity = 64;
    localparam int MaxCapacity = 4096;

    // Port field widths.
    localparam int FuncW  = 4;
    localparam int IndexW = 7;
    localparam int LastW  = 6;
    localparam int CountW = 7;
    localparam int StatW  = 2;

    // Request codes.
    localparam logic [FuncW-1:0] FN_APPEND   = 4'd0;
    localparam logic [FuncW-1:0] FN_PREPEND  = 4'd1;
    localparam logic [FuncW-1:0] FN_INSERT   = 4'd2;
    localparam logic [FuncW-1:0] FN_READ     = 4'd3;
    localparam logic [FuncW-1:0] FN_WRITE    = 4'd4;
    localparam logic [FuncW-1:0] FN_POP_HEAD = 4'd5;
    localparam logic [FuncW-1:0] FN_POP_TAIL = 4'd6;
    localparam logic [FuncW-1:0] FN_REMOVE   = 4'd7;
    localparam logic [FuncW-1:0] FN_RANGE    = 4'd8;
    localparam logic [FuncW-1:0] FN_CLEAR    = 4'd9;

    // Status codes.
    localparam logic [StatW-1:0] ST_OK        = 2'd0;
    localparam logic [StatW-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [StatW-1:0] ST_FULL      = 2'd2;
    localparam logic [StatW-1:0] ST_EMPTY     = 2'd3;

    // The command that every cell of the row carries out.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_WRITE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PosW-1:0]  pos;
        logic [DataW-1:0] value;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_RANGE
    } t_state;

endpackage

`default_nettype wire

### rtl/iol_cell.sv
// One storage cell of the ordered list row: holds a single value and
// trades it with its neighbors on insert and remove. Depends on iol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iol_cell #(
    parameter int CellPos = 0
) (
    input  wire logic                        i_clk,
    input  wire iol_pkg::t_cell_cmd          i_cmd,
    input  wire logic [iol_pkg::PosW-1:0]    i_rd_pos,
    input  wire logic [iol_pkg::DataW-1:0]   i_left,
    input  wire logic [iol_pkg::DataW-1:0]   i_right,
    output logic      [iol_pkg::DataW-1:0]   o_value,
    output logic      [iol_pkg::DataW-1:0]   o_rd
);

    localparam logic [iol_pkg::PosW-1:0] MyPos = iol_pkg::PosW'(CellPos);

    logic [iol_pkg::DataW-1:0] r_value;
    logic [iol_pkg::DataW-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.op)
            iol_pkg::OP_INSERT: begin
                // Cells past the gap take their left neighbor.
                if (MyPos > i_cmd.pos) begin
                    n_value = i_left;
                end else if (MyPos == i_cmd.pos) begin
                    n_value = i_cmd.value;
                end
            end
            iol_pkg::OP_REMOVE: begin
                if (MyPos >= i_cmd.pos) begin
                    n_value = i_right;
                end
            end
            iol_pkg::OP_WRITE: begin
                if (MyPos == i_cmd.pos) begin
                    n_value = i_cmd.value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_rd    = (i_rd_pos == MyPos) ? r_value : '0;

endmodule

`default_nettype wire

### rtl/indexed_ordered_list_core.sv
// Top level of the indexed ordered list: request decode, control sequencer,
// result register and the row of iol_cell storage cells. Depends on iol_pkg.
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_func, i_value, i_index, i_last_index
// result    out        o_out_valid / i_out_stall  o_read_value, o_count, o_status
//
// A range removal keeps the sequencer busy while the cell row moves its contents
// by one position per cycle; every other request loads the result register
// straight from the decode. A new request is taken when the sequencer is idle
// and the result register is empty or being emptied in the same cycle.
// Reset (synchronous, active low) clears the count and the handshake state;
// cell contents are left as they were. A stalled result holds its value.
`default_nettype none

module indexed_ordered_list_core #(
    parameter int CAPACITY = iol_pkg::DefCapacity
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [iol_pkg::FuncW-1:0]     i_func,
    input  wire logic signed [iol_pkg::DataW-1:0] i_value,
    input  wire logic [iol_pkg::IndexW-1:0]    i_index,
    input  wire logic [iol_pkg::LastW-1:0]     i_last_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [iol_pkg::DataW-1:0]   o_read_value,
    output logic      [iol_pkg::CountW-1:0]    o_count,
    output logic      [iol_pkg::StatW-1:0]     o_status
);

    localparam int PW = iol_pkg::PosW;
    localparam int DW = iol_pkg::DataW;
    localparam logic [PW-1:0] CapPos = PW'(CAPACITY);

    // Control registers.
    iol_pkg::t_state r_state;
    iol_pkg::t_state n_state;
    logic [PW-1:0] r_count;
    logic [PW-1:0] n_count;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [PW-1:0] r_left;
    logic [PW-1:0] n_left;
    logic          r_out_valid;
    logic          n_out_valid;

    // Result registers.
    logic [DW-1:0]                 r_read_value;
    logic [DW-1:0]                 n_read_value;
    logic [iol_pkg::CountW-1:0]    r_out_count;
    logic [iol_pkg::CountW-1:0]    n_out_count;
    logic [iol_pkg::StatW-1:0]     r_status;
    logic [iol_pkg::StatW-1:0]     n_status;

    logic in_fire;
    logic out_free;
    logic load_out;

    // Decode of the request at the input.
    logic [PW-1:0]              idx_ext;
    logic [PW-1:0]              last_ext;
    logic [iol_pkg::StatW-1:0]  d_status;
    logic [PW-1:0]              d_count;
    iol_pkg::t_cell_cmd         d_cmd;
    logic                       d_range;
    logic [PW-1:0]              d_span;
    logic [DW-1:0]              d_read;

    iol_pkg::t_cell_cmd cell_cmd;
    logic [DW-1:0] cell_val [CAPACITY];
    logic [DW-1:0] cell_rd  [CAPACITY];
    logic [DW-1:0] rd_any;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != iol_pkg::S_IDLE) || !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign idx_ext  = PW'(i_index);
    assign last_ext = PW'(i_last_index);

    // The addressed cell drives its value, all others drive zero.
    always_comb begin
        rd_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_any = rd_any | cell_rd[k];
        end
    end

    // Request decode: status, new count and the command for the cell row.
    always_comb begin
        d_status = iol_pkg::ST_OK;
        d_count  = r_count;
        d_range  = 1'b0;
        d_span   = last_ext - idx_ext + PW'(1);
        d_read   = '0;
        d_cmd    = '{op: iol_pkg::OP_HOLD, pos: idx_ext, value: i_value};
        unique case (i_func)
            iol_pkg::FN_APPEND: begin
                if (r_count >= CapPos) begin
                    d_status = iol_pkg::ST_FULL;
                end else begin
                    d_cmd.op  = iol_pkg::OP_INSERT;
                    d_cmd.pos = r_count;
                    d_count   = r_count + PW'(1);
                end
            end
            iol_pkg::FN_PREPEND: begin
                if (r_count >= CapPos) begin
                    d_status = iol_pkg::ST_FULL;
                end else begin
                    d_cmd.op  = iol_pkg::OP_INSERT;
                    d_cmd.pos = '0;
                    d_count   = r_count + PW'(1);
                end
            end
            iol_pkg::FN_INSERT: begin
                // The position is checked before the fill level.
                if (idx_ext > r_count) begin
                    d_status = iol_pkg::ST_BAD_INDEX;
                end else if (r_count >= CapPos) begin
                    d_status = iol_pkg::ST_FULL;
                end else begin
                    d_cmd.op = iol_pkg::OP_INSERT;
                    d_count  = r_count + PW'(1);
                end
            end
            iol_pkg::FN_READ: begin
                if (idx_ext >= r_count) begin
                    d_status = iol_pkg::ST_BAD_INDEX;
                end else begin
                    d_read = rd_any;
                end
            end
            iol_pkg::FN_WRITE: begin
                if (idx_ext >= r_count) begin
                    d_status = iol_pkg::ST_BAD_INDEX;
                end else begin
                    d_cmd.op = iol_pkg::OP_WRITE;
                end
            end
            iol_pkg::FN_POP_HEAD: begin
                if (r_count == '0) begin
                    d_status = iol_pkg::ST_EMPTY;
                end else begin
                    d_cmd.op  = iol_pkg::OP_REMOVE;
                    d_cmd.pos = '0;
                    d_count   = r_count - PW'(1);
                end
            end
            iol_pkg::FN_POP_TAIL: begin
                // Dropping the last entry only needs the count.
                if (r_count == '0) begin
                    d_status = iol_pkg::ST_EMPTY;
                end else begin
                    d_count = r_count - PW'(1);
                end
            end
            iol_pkg::FN_REMOVE: begin
                if (idx_ext >= r_count) begin
                    d_status = iol_pkg::ST_BAD_INDEX;
                end else begin
                    d_cmd.op = iol_pkg::OP_REMOVE;
                    d_count  = r_count - PW'(1);
                end
            end
            iol_pkg::FN_RANGE: begin
                if ((idx_ext > last_ext) || (last_ext >= r_count)) begin
                    d_status = iol_pkg::ST_BAD_INDEX;
                end else begin
                    d_range = 1'b1;
                end
            end
            iol_pkg::FN_CLEAR: begin
                d_count = '0;
            end
            default: begin
                d_status = iol_pkg::ST_OK;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iol_pkg::S_IDLE: begin
                if (in_fire && d_range) begin
                    n_state = iol_pkg::S_RANGE;
                end
            end
            iol_pkg::S_RANGE: begin
                if (r_left == PW'(1)) begin
                    n_state = iol_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iol_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs. A range removal closes its gap one position per
    // cycle, always removing at the first position of the range.
    always_comb begin
        cell_cmd     = '{op: iol_pkg::OP_HOLD, pos: r_pos, value: '0};
        n_count      = r_count;
        n_pos        = r_pos;
        n_left       = r_left;
        load_out     = 1'b0;
        n_read_value = r_read_value;
        n_status     = r_status;
        unique case (r_state)
            iol_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_read_value = d_read;
                    n_status     = d_status;
                    if (d_range) begin
                        n_pos  = idx_ext;
                        n_left = d_span;
                    end else begin
                        cell_cmd = d_cmd;
                        n_count  = d_count;
                        load_out = 1'b1;
                    end
                end
            end
            iol_pkg::S_RANGE: begin
                cell_cmd.op = iol_pkg::OP_REMOVE;
                n_count     = r_count - PW'(1);
                n_left      = r_left - PW'(1);
                if (r_left == PW'(1)) begin
                    // A finished range removal reports zero and a good status.
                    load_out     = 1'b1;
                    n_read_value = '0;
                    n_status     = iol_pkg::ST_OK;
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
        n_out_count = iol_pkg::CountW'(n_count);
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iol_pkg::S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (load_out) begin
            r_read_value <= n_read_value;
            r_out_count  <= n_out_count;
            r_status     <= n_status;
        end
    end

    // The cell row. The first cell has no left neighbor and the last cell
    // keeps its own value on a remove; both edges only touch unused space.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DW-1:0] left_val;
        logic [DW-1:0] right_val;
        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end
        iol_cell #(
            .CellPos (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_cmd    (cell_cmd),
            .i_rd_pos (idx_ext),
            .i_left   (left_val),
            .i_right  (right_val),
            .o_value  (cell_val[g]),
            .o_rd     (cell_rd[g])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_count      = r_out_count;
    assign o_status     = r_status;

    // The count never passes the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapPos)
        else $error("stored count exceeds capacity");

    // A clear empties the list at once.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_func == iol_pkg::FN_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the list");

    // A full status is only reported when the store is full.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && (n_status == iol_pkg::ST_FULL)) |-> (r_count == CapPos))
        else $error("full status with free space");

    // A range removal in progress shrinks the list by one each cycle.
    a_range_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iol_pkg::S_RANGE) |=> (r_count == $past(r_count) - PW'(1)))
        else $error("range removal step lost");

    // The sequencer leaves range removal with a result ready.
    a_range_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == iol_pkg::S_RANGE) && (r_left == PW'(1))) |=> o_out_valid)
        else $error("range removal ended without a result");

endmodule

`default_nettype wire

### tb/sv/indexed_ordered_list_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_ordered_list_core: directed and random list requests
// are checked against a behavioral list model held in the bench. Depends on iol_pkg.

module indexed_ordered_list_core_tb;

    localparam int ListCap = iol_pkg::DefCapacity;
    // Cycles in which work is pending but no transfer happens before the run is abandoned.
    localparam int StallLimit = 2000;
    // Quiet cycles after the last result; covers the longest range removal.
    localparam int DrainCycles = 80;
    // Length of the long receiver hold-off.
    localparam int HoldCycles = 160;
    // Func codes that the block does not decode.
    localparam logic [iol_pkg::FuncW-1:0] FN_SPARE_LO = iol_pkg::FN_CLEAR + 4'd1;
    localparam logic [iol_pkg::FuncW-1:0] FN_SPARE_HI = '1;

    typedef struct packed {
        logic signed [iol_pkg::DataW-1:0] read_value;
        logic [iol_pkg::CountW-1:0]       count;
        logic [iol_pkg::StatW-1:0]        status;
    } t_list_result;

    // All inputs start at known values; reset is held from time zero.
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic [iol_pkg::FuncW-1:0]         i_func = '0;
    logic signed [iol_pkg::DataW-1:0]  i_value = '0;
    logic [iol_pkg::IndexW-1:0]        i_index = '0;
    logic [iol_pkg::LastW-1:0]         i_last_index = '0;
    logic                              i_out_stall = 1'b0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic signed [iol_pkg::DataW-1:0]  o_read_value;
    logic [iol_pkg::CountW-1:0]        o_count;
    logic [iol_pkg::StatW-1:0]         o_status;

    // Shadow copy of the list contents and length, updated at each accepted request.
    logic signed [iol_pkg::DataW-1:0] list_vals [ListCap];
    int                               list_len = 0;
    // Results predicted for accepted requests, oldest first.
    t_list_result                     expected_results [$];

    int error_count = 0;
    // Sender burst bookkeeping; no_gaps keeps the sender offering back to back.
    int burst_left = 0;
    bit no_gaps = 1'b0;
    // The receiver process compares these to start a long hold-off.
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_mode_left = 0;
    int idle_cycles = 0;
    // Random traffic drifts between filling and draining the list.
    bit growing = 1'b1;

    always #2 i_clk = ~i_clk;

    indexed_ordered_list_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_last_index (i_last_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    // Opens a slot at pos by moving the tail up one place.
    function automatic void list_open_gap(input int pos,
                                          input logic signed [iol_pkg::DataW-1:0] v);
        for (int p = list_len; p > pos; p--) begin
            list_vals[p] = list_vals[p-1];
        end
        list_vals[pos] = v;
        list_len++;
    endfunction

    // Removes n entries starting at first and closes the hole.
    function automatic void list_close_span(input int first, input int n);
        for (int p = first; p + n < list_len; p++) begin
            list_vals[p] = list_vals[p+n];
        end
        list_len -= n;
    endfunction

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic t_list_result predict_list_op(
        input logic [iol_pkg::FuncW-1:0]        func,
        input logic signed [iol_pkg::DataW-1:0] value,
        input logic [iol_pkg::IndexW-1:0]       index,
        input logic [iol_pkg::LastW-1:0]        last
    );
        t_list_result res;
        int idx;
        int lst;
        idx = int'(index);
        lst = int'(last);
        res.read_value = '0;
        res.status = iol_pkg::ST_OK;
        case (func)
            iol_pkg::FN_APPEND: begin
                if (list_len >= ListCap) res.status = iol_pkg::ST_FULL;
                else list_open_gap(list_len, value);
            end
            iol_pkg::FN_PREPEND: begin
                if (list_len >= ListCap) res.status = iol_pkg::ST_FULL;
                else list_open_gap(0, value);
            end
            iol_pkg::FN_INSERT: begin
                // The position is checked before fullness.
                if (idx > list_len) res.status = iol_pkg::ST_BAD_INDEX;
                else if (list_len >= ListCap) res.status = iol_pkg::ST_FULL;
                else list_open_gap(idx, value);
            end
            iol_pkg::FN_READ: begin
                if (idx >= list_len) res.status = iol_pkg::ST_BAD_INDEX;
                else res.read_value = list_vals[idx];
            end
            iol_pkg::FN_WRITE: begin
                if (idx >= list_len) res.status = iol_pkg::ST_BAD_INDEX;
                else list_vals[idx] = value;
            end
            iol_pkg::FN_POP_HEAD: begin
                if (list_len == 0) res.status = iol_pkg::ST_EMPTY;
                else list_close_span(0, 1);
            end
            iol_pkg::FN_POP_TAIL: begin
                if (list_len == 0) res.status = iol_pkg::ST_EMPTY;
                else list_len--;
            end
            iol_pkg::FN_REMOVE: begin
                if (idx >= list_len) res.status = iol_pkg::ST_BAD_INDEX;
                else list_close_span(idx, 1);
            end
            iol_pkg::FN_RANGE: begin
                if (idx > lst || lst >= list_len) res.status = iol_pkg::ST_BAD_INDEX;
                else list_close_span(idx, lst - idx + 1);
            end
            iol_pkg::FN_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.count = iol_pkg::CountW'(list_len);
        return res;
    endfunction

    // Offers one request and returns once it has been accepted. The sender runs in bursts;
    // a gap between bursts lowers valid before valid rises again.
    task automatic send_request(
        input logic [iol_pkg::FuncW-1:0]        func,
        input logic signed [iol_pkg::DataW-1:0] value,
        input logic [iol_pkg::IndexW-1:0]       index,
        input logic [iol_pkg::LastW-1:0]        last
    );
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_value      <= value;
        i_index      <= index;
        i_last_index <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_results.push_back(predict_list_op(func, value, index, last));
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Mostly random values, with the signed extremes mixed in.
    function automatic logic signed [iol_pkg::DataW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // One random request. Most are well formed for the current length so that the list
    // really fills, shifts and drains; the rest are raw noise over every field bit.
    task automatic send_random_request();
        int r;
        int first;
        int last;
        logic [iol_pkg::FuncW-1:0] func;
        if (list_len == ListCap && $urandom_range(0, 4) == 0) growing = 1'b0;
        if (list_len == 0 && $urandom_range(0, 4) == 0) growing = 1'b1;
        if ($urandom_range(0, 199) == 0) growing = ~growing;

        if ($urandom_range(0, 9) == 0) begin
            send_request(iol_pkg::FuncW'($urandom_range(0, 15)), $urandom,
                         iol_pkg::IndexW'($urandom_range(0, 127)),
                         iol_pkg::LastW'($urandom_range(0, 63)));
        end else begin
            r = $urandom_range(0, 199);
            if (growing) begin
                if (r < 50) func = iol_pkg::FN_APPEND;
                else if (r < 80) func = iol_pkg::FN_PREPEND;
                else if (r < 120) func = iol_pkg::FN_INSERT;
                else if (r < 150) func = iol_pkg::FN_READ;
                else if (r < 170) func = iol_pkg::FN_WRITE;
                else if (r < 178) func = iol_pkg::FN_POP_HEAD;
                else if (r < 186) func = iol_pkg::FN_POP_TAIL;
                else if (r < 194) func = iol_pkg::FN_REMOVE;
                else if (r < 199) func = iol_pkg::FN_RANGE;
                else func = iol_pkg::FN_CLEAR;
            end else begin
                if (r < 10) func = iol_pkg::FN_APPEND;
                else if (r < 15) func = iol_pkg::FN_PREPEND;
                else if (r < 25) func = iol_pkg::FN_INSERT;
                else if (r < 60) func = iol_pkg::FN_READ;
                else if (r < 80) func = iol_pkg::FN_WRITE;
                else if (r < 110) func = iol_pkg::FN_POP_HEAD;
                else if (r < 140) func = iol_pkg::FN_POP_TAIL;
                else if (r < 170) func = iol_pkg::FN_REMOVE;
                else if (r < 199) func = iol_pkg::FN_RANGE;
                else func = iol_pkg::FN_CLEAR;
            end
            first = (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
            last = $urandom_range(0, 63);
            if (func == iol_pkg::FN_INSERT) begin
                first = $urandom_range(0, list_len);
            end else if (func == iol_pkg::FN_RANGE && list_len > 0) begin
                // Short spans keep range removal cheap; now and then a long one.
                if ($urandom_range(0, 9) == 0) last = $urandom_range(first, list_len - 1);
                else last = (first + $urandom_range(0, 2) < list_len)
                            ? first + $urandom_range(0, 2) : list_len - 1;
            end
            send_request(func, pick_value(), iol_pkg::IndexW'(first), iol_pkg::LastW'(last));
        end
    endtask

    // Every position-taking request on an empty list, plus the empty pops.
    task automatic test_empty_list();
        send_request(iol_pkg::FN_POP_HEAD, 32'sd1, '0, '0);
        send_request(iol_pkg::FN_POP_TAIL, 32'sd2, '0, '0);
        send_request(iol_pkg::FN_READ, '0, '0, '0);
        send_request(iol_pkg::FN_WRITE, 32'sd5, '0, '0);
        send_request(iol_pkg::FN_REMOVE, '0, '0, '0);
        send_request(iol_pkg::FN_RANGE, '0, '0, '0);
        send_request(iol_pkg::FN_INSERT, 32'sd7, 7'd1, '0);
    endtask

    // Every operation but the pops on a short list, with extreme values and indexes.
    task automatic test_basic_ops();
        send_request(iol_pkg::FN_INSERT, 32'sh7fff_ffff, '0, '0);
        send_request(iol_pkg::FN_APPEND, 32'sh8000_0000, '0, '0);
        send_request(iol_pkg::FN_PREPEND, '1, '0, '0);
        // Insert at the current length behaves like append.
        send_request(iol_pkg::FN_INSERT, '0, 7'd3, '0);
        send_request(iol_pkg::FN_READ, '0, 7'd0, '0);
        send_request(iol_pkg::FN_READ, '0, 7'd3, '0);
        send_request(iol_pkg::FN_READ, '0, 7'd4, '0);
        send_request(iol_pkg::FN_READ, '0, '1, '1);
        send_request(iol_pkg::FN_WRITE, 32'sh5555_5555, 7'd1, '0);
        send_request(iol_pkg::FN_READ, '0, 7'd1, '0);
        // Range checks: first above last, and last at the length.
        send_request(iol_pkg::FN_RANGE, '0, 7'd2, 6'd1);
        send_request(iol_pkg::FN_RANGE, '0, 7'd0, 6'd4);
        send_request(iol_pkg::FN_RANGE, '0, 7'd1, 6'd2);
        send_request(iol_pkg::FN_REMOVE, '0, 7'd0, '0);
        send_request(iol_pkg::FN_READ, '0, 7'd0, '0);
        send_request(FN_SPARE_LO, 32'sd9, 7'd0, '0);
        send_request(FN_SPARE_HI, '1, '1, '1);
        send_request(iol_pkg::FN_CLEAR, '0, '0, '0);
    endtask

    // Fills the store, hits every full case, then removes the whole list in one range.
    task automatic test_full_store();
        for (int n = 0; n < ListCap; n++) begin
            send_request(iol_pkg::FN_APPEND, pick_value(), '0, '0);
        end
        send_request(iol_pkg::FN_APPEND, 32'sd11, '0, '0);
        send_request(iol_pkg::FN_PREPEND, 32'sd12, '0, '0);
        send_request(iol_pkg::FN_INSERT, 32'sd13, 7'd10, '0);
        // Position is checked first, so this is a bad index even though the store is full.
        send_request(iol_pkg::FN_INSERT, 32'sd14, 7'd65, '0);
        send_request(iol_pkg::FN_READ, '0, 7'd63, '0);
        send_request(iol_pkg::FN_READ, '0, 7'd64, '0);
        send_request(iol_pkg::FN_RANGE, '0, 7'd0, 6'd63);
        send_request(iol_pkg::FN_POP_TAIL, '0, '0, '0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering back to
    // back, so the block fills up and must stall its input.
    task automatic test_stalled_output();
        no_gaps = 1'b1;
        burst_left = 0;
        hold_requests++;
        for (int n = 0; n < 200; n++) begin
            send_random_request();
        end
        no_gaps = 1'b0;
    endtask

    // The sender stops until every result is back, then resumes.
    task automatic test_drain_pause();
        for (int n = 0; n < 40; n++) begin
            send_random_request();
        end
        wait_results_drained();
        for (int n = 0; n < 40; n++) begin
            send_random_request();
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int n = 0; n < n_items; n++) begin
            send_random_request();
        end
    endtask

    // Receiver back-pressure. A pending long hold-off wins; otherwise the stall pattern
    // switches between modes at random times, including a mode with no stalls.
    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HoldCycles;
        end
        if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            stall_mode_left = $urandom_range(20, 300);
        end
        stall_mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= $urandom_range(0, 1);
                3: i_out_stall <= ($urandom_range(0, 9) != 0);
                default: i_out_stall <= (stall_mode_left % 4 < 2);
            endcase
        end
    end

    // Result checker: each transfer on the result channel is compared field by field with
    // the oldest prediction. Outputs are read at the edge, before the block updates them.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: read_value %0d count %0d status %0d",
                       o_read_value, o_count, o_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value expected %0d actual %0d", want.read_value, o_read_value);
                    error_count++;
                end
                if (o_count !== want.count) begin
                    $error("count expected %0d actual %0d", want.count, o_count);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with work pending but no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
            || (o_out_valid === 1'b1 && !i_out_stall)
            || (expected_results.size() == 0 && !i_in_valid)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= StallLimit) begin
            $display("indexed_ordered_list_core_tb: errors");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < ListCap; n++) begin
            list_vals[n] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_basic_ops();
        test_full_store();
        test_stalled_output();
        test_drain_pause();
        test_random_traffic(1400);

        // Let the last results come back and give the block time to show anything extra.
        wait_results_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("indexed_ordered_list_core_tb: clean");
        end else begin
            $display("indexed_ordered_list_core_tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/iol_pkg.sv
rtl/iol_cell.sv
rtl/indexed_ordered_list_core.sv
tb/sv/indexed_ordered_list_core_tb.sv
